// ===== rtl/sus_pkg.sv =====
// Shared types and constants for the sorted unique set.
package sus_pkg;

  localparam int DefCapacity = 16;
  localparam int ValueW      = 32;
  localparam int CountOutW   = 5;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic load;
    logic do_insert;
    logic do_delete;
  } sus_cmd_t;

  typedef struct packed {
    logic       hit;
    logic       full;
    logic [1:0] cmd;
  } sus_stat_t;

endpackage

// ===== rtl/sorted_unique_set.sv =====
// Top level: bounded sorted set of distinct signed 32-bit values.
// Each accepted word passes through the compare and update steps before the result is valid.
// A new request is accepted only after the previous result has been taken.
// The compare step checks all slots in parallel; the update shifts the slots from the key's position up.
// Reset (rst_n low, synchronous) empties the set and returns to idle.
module sorted_unique_set import sus_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[1:0], value[33:2], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status[1:0], entry_count[6:2], is_empty[7]
);

  sus_cmd_t  ctl;
  sus_stat_t stat;
  logic [1:0] status;
  logic [CountOutW-1:0] count_lo;
  logic empty;

  sus_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .ctl       (ctl),
    .status_r  (status)
  );

  sus_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_cmd   (in_tdata[1:0]),
    .in_value (in_tdata[33:2]),
    .stat     (stat),
    .count_lo (count_lo),
    .empty    (empty)
  );

  assign out_tdata = {empty, count_lo, status};

endmodule

// ===== rtl/sus_datapath.sv =====
// Slot array with parallel compare and shift for insert and delete.
module sus_datapath import sus_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sus_cmd_t                ctl,
  input  logic [1:0]              in_cmd,
  input  logic signed [ValueW-1:0] in_value,
  output sus_stat_t               stat,
  output logic [CountOutW-1:0]    count_lo,
  output logic                    empty
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [ValueW-1:0] slot_r [CAPACITY];
  logic [ValueW-1:0] slot_nxt [CAPACITY];
  logic [CAPACITY-1:0] valid_r;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic [1:0] cmd_r;
  logic [ValueW-1:0] key_r;
  logic [CAPACITY-1:0] ge_r;
  logic [CAPACITY-1:0] eq_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      key_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge_r[i] <= valid_r[i] &&
                 ($signed(slot_r[i]) >= $signed(key_r));
      eq_r[i] <= valid_r[i] && (slot_r[i] == key_r);
    end
  end

  assign stat.hit  = |eq_r;
  assign stat.full = (count_r == CntW'(CAPACITY));
  assign stat.cmd  = cmd_r;

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_nxt[i] = slot_r[i];
      if (ctl.do_insert) begin
        if (ge_r[i]) begin
          slot_nxt[i] = (i == 0) ? key_r : (ge_r[(i == 0) ? 0 : i - 1]
                        ? slot_r[(i == 0) ? 0 : i - 1] : key_r);
        end else if (!valid_r[i] && (i == 0 || valid_r[(i == 0) ? 0 : i - 1])) begin
          slot_nxt[i] = (i == 0) ? key_r : (ge_r[(i == 0) ? 0 : i - 1]
                        ? slot_r[(i == 0) ? 0 : i - 1] : key_r);
        end
      end else if (ctl.do_delete) begin
        if (ge_r[i] && i + 1 < CAPACITY) begin
          slot_nxt[i] = slot_r[(i + 1 < CAPACITY) ? i + 1 : i];
        end
      end
    end
    if (ctl.do_insert) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.do_delete) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= '0;
    end else begin
      count_r <= count_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        valid_r[i] <= (CntW'(i) < count_nxt);
      end
    end
  end

  assign count_lo = CountOutW'(count_r);
  assign empty    = (count_r == '0);

endmodule

// ===== rtl/sus_ctrl.sv =====
// Request sequencer: load, compare, update, then present the result.
module sus_ctrl import sus_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  sus_stat_t  stat,
  output sus_cmd_t   ctl,
  output logic [1:0] status_r
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_UPD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] status_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    ctl.load      = 1'b0;
    ctl.do_insert = 1'b0;
    ctl.do_delete = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: state_nxt = S_UPD;
      S_UPD: begin
        state_nxt = S_OUT;
        case (stat.cmd)
          CMD_INSERT: begin
            if (stat.hit) begin
              status_nxt = ST_DUP;
            end else if (stat.full) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt    = ST_DONE;
              ctl.do_insert = 1'b1;
            end
          end
          CMD_DELETE: begin
            status_nxt    = stat.hit ? ST_DONE : ST_ABSENT;
            ctl.do_delete = stat.hit;
          end
          default: status_nxt = stat.hit ? ST_DONE : ST_ABSENT;
        endcase
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    status_r <= status_nxt;
  end

endmodule
